@@ rtl/bpa_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package bpa_pkg;
  localparam int MapBits = 4096;
  localparam int MapBytes = MapBits / 8;
  localparam int AddrW = $clog2(MapBytes);
  localparam int IdxW = 12;
  localparam int CntW = 13;

  localparam logic [1:0] OP_ALLOC = 2'd0;
  localparam logic [1:0] OP_FREE = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;

  localparam logic [2:0] ST_OK = 3'd0;
  localparam logic [2:0] ST_UNINIT = 3'd1;
  localparam logic [2:0] ST_NOSPACE = 3'd2;
  localparam logic [2:0] ST_RANGE = 3'd3;
  localparam logic [2:0] ST_NOTALLOC = 3'd4;
  localparam logic [2:0] ST_ZERO = 3'd5;

  // datapath sequencing commands
  typedef enum logic [2:0] {
    CMD_NONE   = 3'd0,
    CMD_LOAD   = 3'd1,  // latch item, compute checks
    CMD_SCAN   = 3'd2,  // single alloc: byte scan for clear bit
    CMD_CHECK  = 3'd3,  // free: verify range set
    CMD_WRITE  = 3'd4,  // set or clear range
    CMD_WALK   = 3'd5,  // mark walk-down
    CMD_WIPE   = 3'd6   // clear sweep
  } cmd_t;

  typedef struct packed {
    cmd_t cmd;
    logic set_bits;
  } ctl_t;

  typedef struct packed {
    logic       done;     // current step finished
    logic       fail;     // immediate/scan/check error
    logic       is_alloc;
    logic       is_free;
    logic       is_clear;
    logic       is_single;
  } sts_t;
endpackage
`default_nettype wire

@@ rtl/bpa_datapath.sv @@
`timescale 1ns / 1ps
`default_nettype none
module bpa_datapath (
  input  wire logic clk,
  input  wire logic rst,
  input  wire bpa_pkg::ctl_t ctl,
  output bpa_pkg::sts_t sts,
  input  wire logic [1:0] opcode,
  input  wire logic [11:0] start_index,
  input  wire logic [12:0] unit_count,
  input  wire logic [12:0] total_units,
  output logic [2:0] status,
  output logic [11:0] index_out,
  output logic [12:0] used_out,
  output logic [12:0] mark_out
);
  import bpa_pkg::*;

  logic [7:0] mem [MapBytes];
  logic [CntW-1:0] used, mark, lo, hi, ptr, cnt;
  logic [1:0] op;
  logic fail;
  logic phase; // 0: issue read / 1: data valid
  logic [7:0] rdata;
  logic [AddrW-1:0] raddr;

  wire [13:0] tot_w = (total_units > 13'(MapBits)) ? 14'(MapBits) : 14'(total_units);

  // range mask within byte at ptr covering [ptr, hi)
  logic [CntW-1:0] bbase;
  logic [7:0] rmask;
  logic [3:0] nlast;
  always_comb begin
    bbase = {ptr[CntW-1:3], 3'b000};
    nlast = ((hi - bbase) > 13'd8) ? 4'd8 : 4'(hi - bbase);
    rmask = 8'((9'h1 << nlast) - 9'h1) & 8'(8'hFF << ptr[2:0]);
  end

  // first clear bit in rdata, limited below tot
  logic [7:0] freev;
  logic       anyf;
  logic [2:0] fpos;
  always_comb begin
    freev = ~rdata & rmask;
    anyf = |freev;
    fpos = 3'd0;
    for (int b = 7; b >= 0; b--) if (freev[b]) fpos = 3'(b);
  end

  assign raddr = ctl.cmd == CMD_WALK ? AddrW'((mark - 13'd1) >> 3) : ptr[AddrW+2:3];

  always_ff @(posedge clk) rdata <= mem[raddr];

  logic done;
  always_ff @(posedge clk) begin
    if (rst) begin
      used <= '0; mark <= '0; phase <= 1'b0; fail <= 1'b0; ptr <= '0; done <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (ctl.cmd)
        CMD_LOAD: begin
          op <= opcode; cnt <= unit_count;
          phase <= 1'b0; fail <= 1'b0; status <= ST_OK; index_out <= '0;
          if (opcode == OP_ALLOC) begin
            if (tot_w == 0) begin fail <= 1'b1; status <= ST_UNINIT; end
            else if (unit_count == 0) begin fail <= 1'b1; status <= ST_ZERO; end
            else if (unit_count == 13'd1) begin
              if (14'(used) >= tot_w) begin fail <= 1'b1; status <= ST_NOSPACE; end
              ptr <= '0; hi <= 13'(tot_w);
            end else if (14'(mark) + 14'(unit_count) > tot_w) begin
              fail <= 1'b1; status <= ST_NOSPACE;
            end else begin
              ptr <= mark; lo <= mark; hi <= 13'(14'(mark) + 14'(unit_count));
              index_out <= mark[11:0];
            end
          end else if (opcode == OP_FREE) begin
            if (unit_count == 0) begin fail <= 1'b1; status <= ST_ZERO; end
            else if (14'(start_index) + 14'(unit_count) > tot_w) begin
              fail <= 1'b1; status <= ST_RANGE;
            end else begin
              ptr <= 13'(start_index); lo <= 13'(start_index);
              hi <= 13'(14'(start_index) + 14'(unit_count));
              index_out <= start_index;
            end
          end else begin
            ptr <= '0;
          end
        end
        CMD_SCAN: begin
          phase <= ~phase;
          if (phase) begin
            if (anyf) begin
              mem[ptr[AddrW+2:3]] <= rdata | (8'h1 << fpos);
              index_out <= 12'({ptr[CntW-1:3], fpos});
              used <= used + 13'd1;
              if ({ptr[CntW-1:3], fpos} >= mark) mark <= {ptr[CntW-1:3], fpos} + 13'd1;
              done <= 1'b1;
            end else if (bbase + 13'd8 >= hi) begin
              fail <= 1'b1; status <= ST_NOSPACE; done <= 1'b1;
            end else ptr <= bbase + 13'd8;
          end
        end
        CMD_CHECK: begin
          phase <= ~phase;
          if (phase) begin
            if ((rdata & rmask) != rmask) begin
              fail <= 1'b1; status <= ST_NOTALLOC; index_out <= '0; done <= 1'b1;
            end else if (bbase + 13'd8 >= hi) begin
              ptr <= lo; done <= 1'b1;
            end else ptr <= bbase + 13'd8;
          end
        end
        CMD_WRITE: begin
          phase <= ~phase;
          if (phase) begin
            mem[ptr[AddrW+2:3]] <= ctl.set_bits ? (rdata | rmask) : (rdata & ~rmask);
            if (bbase + 13'd8 >= hi) begin
              done <= 1'b1;
              if (ctl.set_bits) begin mark <= hi; used <= used + cnt; end
              else used <= (used >= cnt) ? used - cnt : '0;
            end else ptr <= bbase + 13'd8;
          end
        end
        CMD_WALK: begin
          phase <= ~phase;
          if (mark == 0) done <= 1'b1;
          else if (phase) begin
            if (rdata[3'(mark - 13'd1)]) done <= 1'b1;
            else mark <= mark - 13'd1;
          end
        end
        CMD_WIPE: begin
          mem[ptr[AddrW+2:3]] <= 8'h00;
          ptr <= ptr + 13'd8;
          if (ptr[AddrW+2:3] == AddrW'(MapBytes - 1)) begin
            done <= 1'b1; used <= '0; mark <= '0;
          end
        end
        default: ;
      endcase
    end
  end

  assign sts.done = done;
  assign sts.fail = fail;
  assign sts.is_alloc = op == OP_ALLOC;
  assign sts.is_free = op == OP_FREE;
  assign sts.is_clear = op == OP_CLEAR;
  assign sts.is_single = cnt == 13'd1;
  assign used_out = used;
  assign mark_out = mark;
endmodule
`default_nettype wire

@@ rtl/bpa_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none
module bpa_ctrl (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  output logic in_ready,
  output logic out_valid,
  input  wire logic out_ready,
  output bpa_pkg::ctl_t ctl,
  input  wire bpa_pkg::sts_t sts
);
  import bpa_pkg::*;

  typedef enum logic [7:0] {
    S_IDLE = 8'b00000001, S_LOAD = 8'b00000010, S_SCAN = 8'b00000100,
    S_CHECK = 8'b00001000, S_WRITE = 8'b00010000, S_WALK = 8'b00100000,
    S_WIPE = 8'b01000000, S_OUT = 8'b10000000
  } state_t;

  state_t state, state_next;
  logic setb;
  logic boot; // map sweep after reset, no result

  assign in_ready = state == S_IDLE;
  assign out_valid = state == S_OUT;

  always_comb begin
    state_next = state;
    ctl.cmd = CMD_NONE;
    ctl.set_bits = setb;
    unique case (state)
      S_IDLE: if (in_valid) begin ctl.cmd = CMD_LOAD; state_next = S_LOAD; end
      S_LOAD: begin
        priority if (sts.fail) state_next = S_OUT;
        else if (sts.is_clear) state_next = S_WIPE;
        else if (sts.is_alloc && sts.is_single) state_next = S_SCAN;
        else if (sts.is_alloc) state_next = S_WRITE;
        else if (sts.is_free) state_next = S_CHECK;
        else state_next = S_OUT;
      end
      S_SCAN: begin ctl.cmd = CMD_SCAN; if (sts.done) state_next = S_OUT; end
      S_CHECK: begin
        ctl.cmd = CMD_CHECK;
        if (sts.done) state_next = sts.fail ? S_OUT : S_WRITE;
      end
      S_WRITE: begin
        ctl.cmd = CMD_WRITE;
        if (sts.done) state_next = sts.is_free ? S_WALK : S_OUT;
      end
      S_WALK: begin ctl.cmd = CMD_WALK; if (sts.done) state_next = S_OUT; end
      S_WIPE: begin
        ctl.cmd = CMD_WIPE;
        if (sts.done) state_next = boot ? S_IDLE : S_OUT;
      end
      S_OUT: if (out_ready) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
    // done is registered: issue no command while it is high, so the next step does not start early
    if (state != S_IDLE && state != S_LOAD && state != S_OUT && sts.done) ctl.cmd = CMD_NONE;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_WIPE; setb <= 1'b0; boot <= 1'b1;
    end else begin
      state <= state_next;
      if (state == S_LOAD) setb <= sts.is_alloc;
      if (state == S_WIPE && sts.done) boot <= 1'b0;
    end
  end
endmodule
`default_nettype wire

@@ rtl/bitmap_page_allocator_unit.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Bitmap page allocator: one request at a time, one result per request.
// Map is a 512 x 8 RAM walked byte by byte, each read then updated; clear only
// writes zeroes. Single alloc scans for a clear bit, block alloc sets its range,
// free checks the range is set, clears it and walks the mark down bit by bit.
// After reset the map is swept to zero before the first request is taken. The
// user must write total_units only while idle; the block does not enforce it.
module bitmap_page_allocator_unit (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic cfg_valid,
  output logic cfg_ready,
  input  wire logic [12:0] cfg_data,
  input  wire logic in_valid,
  output logic in_ready,
  input  wire logic [1:0] opcode,
  input  wire logic [11:0] start_index,
  input  wire logic [12:0] unit_count,
  output logic out_valid,
  input  wire logic out_ready,
  output logic [2:0] status,
  output logic [11:0] index_out,
  output logic [12:0] used_out,
  output logic [12:0] mark_out
);
  import bpa_pkg::*;

  logic [12:0] total_units;
  ctl_t ctl;
  sts_t sts;

  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) total_units <= 13'd4096;
    else if (cfg_valid) total_units <= cfg_data;
  end

  bpa_ctrl u_ctrl (.clk, .rst, .in_valid, .in_ready, .out_valid, .out_ready, .ctl, .sts);

  bpa_datapath u_dp (.clk, .rst, .ctl, .sts, .opcode, .start_index, .unit_count,
    .total_units, .status, .index_out, .used_out, .mark_out);

  a_mark: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> mark_out <= 13'(MapBits)) else $error("mark out of range");
  a_excl: assert property (@(posedge clk) disable iff (rst)
    !(in_ready && out_valid)) else $error("accept during result");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(used_out))
    else $error("result changed while stalled");
endmodule
`default_nettype wire
